// ===== sv/rbi_pkg.sv =====
// Package for the ray/box intersection unit: widths, tolerances and the face table.
// Used by every module of the block; it depends on nothing.
`timescale 1ns / 1ps
package rbi_pkg;

  localparam int CoordWidth = 32;
  localparam int PlaneWidth = CoordWidth + 1;
  localparam int SlackWidth = CoordWidth + 2;
  localparam int AccWidth   = 2 * CoordWidth + 5;
  localparam int FracBits   = 16;
  localparam int NumerWidth = PlaneWidth + FracBits;
  localparam int DistWidth  = 31;
  localparam int NumFaces   = 6;
  localparam int BitCntW    = $clog2(NumerWidth + 1);

  localparam logic [PlaneWidth-1:0] NearLsb  = PlaneWidth'(10);
  localparam logic [SlackWidth-1:0] SlackLsb = SlackWidth'(98);
  localparam logic [DistWidth-1:0]  DistMax  = {DistWidth{1'b1}};

  function automatic logic [1:0] face_axis(input logic [2:0] face);
    case (face)
      3'd0, 3'd1: face_axis = 2'd1;
      3'd2, 3'd3: face_axis = 2'd0;
      default:    face_axis = 2'd2;
    endcase
  endfunction

endpackage

// ===== sv/rbi_cell.sv =====
// One cell of the plane check chain: accumulates (plane + slack) * |cos| + cos_j * |dist|
// one multiplier bit per cycle while step_i is high; ANDs its verdict into the chain. Uses rbi_pkg.
`timescale 1ns / 1ps
module rbi_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  logic                                 step_i,
  input  logic signed [rbi_pkg::SlackWidth-1:0] pv_i,
  input  logic signed [rbi_pkg::PlaneWidth-1:0] pc_i,
  input  logic                                 cm_bit_i,
  input  logic                                 dm_bit_i,
  input  logic                                 skip_i,
  input  logic                                 ok_i,
  output logic                                 ok_o
);
  import rbi_pkg::*;

  logic signed [AccWidth-1:0] acc_q, acc_d;

  always_comb begin
    acc_d = acc_q <<< 1;
    if (cm_bit_i) begin
      acc_d = acc_d + AccWidth'(pv_i);
    end
    if (dm_bit_i) begin
      acc_d = acc_d + AccWidth'(pc_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clear_i) begin
      acc_q <= '0;
    end else if (step_i) begin
      acc_q <= acc_d;
    end
  end

  assign ok_o = ok_i & (skip_i | ~acc_q[AccWidth-1]);

endmodule

// ===== sv/rbi_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(dm * 2^16 / cm).
// The caller rules out quotients that do not fit. Depends on rbi_pkg.
`timescale 1ns / 1ps
module rbi_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rbi_pkg::PlaneWidth-1:0]    dm_i,
  input  logic [rbi_pkg::PlaneWidth-1:0]    cm_i,
  output logic                              done_o,
  output logic [rbi_pkg::DistWidth-1:0]     quo_o
);
  import rbi_pkg::*;

  logic                  busy_q;
  logic [BitCntW-1:0]    cnt_q;
  logic [NumerWidth-1:0] num_q;
  logic [PlaneWidth:0]   rem_q, rem_sh;
  logic [DistWidth-1:0]  quo_q;
  logic                  done_q;
  logic                  fits;

  assign rem_sh = {rem_q[PlaneWidth-1:0], num_q[NumerWidth-1]};
  assign fits   = rem_sh >= {1'b0, cm_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= BitCntW'(NumerWidth);
        num_q  <= {dm_i, {FracBits{1'b0}}};
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        num_q <= num_q << 1;
        rem_q <= fits ? rem_sh - {1'b0, cm_i} : rem_sh;
        quo_q <= {quo_q[DistWidth-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == BitCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/ray_box_intersect_unit.sv =====
// Top level of the ray/box intersection unit: box registers, face sequencer,
// a chain of six plane check cells and the distance divider. Depends on rbi_pkg,
// rbi_cell and rbi_div.
//
//   Port group       Direction  Meaning
//   start/busy       in/out     ray item accepted when start is high and busy low
//   origin/direction in         ray, signed Q16.16
//   cfg_*            in         box corner writes, index 0..5
//   done_o           out        one-cycle strobe with hit_o and hit_distance_o
//
// An item tries up to six faces in turn; a face not settled by the near and sign tests goes
// through the multiply and check states of the chain, and a hit whose distance does not
// saturate then waits for the divider. done_o rises in the same cycle that busy falls.
// Reset clears the box to zero and idles the sequencer. The result is shown for
// one cycle and cannot be stalled.
`timescale 1ns / 1ps
module ray_box_intersect_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            origin_x_i,
  input  logic signed [31:0]            origin_y_i,
  input  logic signed [31:0]            origin_z_i,
  input  logic signed [31:0]            direction_x_i,
  input  logic signed [31:0]            direction_y_i,
  input  logic signed [31:0]            direction_z_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [rbi_pkg::DistWidth-1:0] hit_distance_o
);
  import rbi_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_FACE, S_MUL, S_CHK, S_DIV} state_e;

  localparam logic [2:0] IdxMinX = 3'd0;
  localparam logic [2:0] IdxMinY = 3'd1;
  localparam logic [2:0] IdxMinZ = 3'd2;
  localparam logic [2:0] IdxMaxX = 3'd3;
  localparam logic [2:0] IdxMaxY = 3'd4;
  localparam logic [2:0] IdxMaxZ = 3'd5;
  localparam logic [2:0] LastFace = 3'(NumFaces - 1);
  localparam int MulBitW = $clog2(PlaneWidth);

  state_e state_q;
  logic [2:0] face_q;
  logic [MulBitW-1:0] bit_q;
  logic signed [CoordWidth-1:0] org_q [3];
  logic signed [CoordWidth-1:0] dir_q [3];
  logic signed [CoordWidth-1:0] lo_q [3];
  logic signed [CoordWidth-1:0] hi_q [3];
  logic [PlaneWidth-1:0] dm_q, cm_q;
  logic done_q, hit_q;
  logic [DistWidth-1:0] dist_q;

  logic signed [PlaneWidth-1:0] pv [NumFaces];
  logic signed [PlaneWidth-1:0] pc [NumFaces];
  logic signed [SlackWidth-1:0] pvs [NumFaces];
  logic [NumFaces:0] ok_chain;
  logic signed [PlaneWidth-1:0] dist_s, cos_s;
  logic [PlaneWidth-1:0] dm, cm;
  logic cells_clear, cells_step, div_start, div_done, sat;
  logic [DistWidth-1:0] div_quo;

  always_comb begin
    for (int j = 0; j < NumFaces; j++) begin
      logic [1:0] ax;
      ax = face_axis(3'(j));
      if (j % 2 == 1) begin
        pv[j] = PlaneWidth'(hi_q[ax]) - PlaneWidth'(org_q[ax]);
        pc[j] = -PlaneWidth'(dir_q[ax]);
      end else begin
        pv[j] = PlaneWidth'(org_q[ax]) - PlaneWidth'(lo_q[ax]);
        pc[j] = PlaneWidth'(dir_q[ax]);
      end
      pvs[j] = SlackWidth'(pv[j]) + SlackLsb;
    end
  end

  assign dist_s = pv[face_q];
  assign cos_s  = pc[face_q];
  assign dm = dist_s[PlaneWidth-1] ? PlaneWidth'(-dist_s) : PlaneWidth'(dist_s);
  assign cm = cos_s[PlaneWidth-1] ? PlaneWidth'(-cos_s) : PlaneWidth'(cos_s);
  assign sat = {{FracBits-1{1'b0}}, dm_q} >=
               {cm_q, {DistWidth-FracBits{1'b0}}};

  assign cells_clear = (state_q == S_FACE);
  assign cells_step  = (state_q == S_MUL);
  assign ok_chain[0] = 1'b1;

  for (genvar g = 0; g < NumFaces; g++) begin : g_cell
    rbi_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (cells_clear),
      .step_i   (cells_step),
      .pv_i     (pvs[g]),
      .pc_i     (pc[g]),
      .cm_bit_i (cm_q[bit_q]),
      .dm_bit_i (dm_q[bit_q]),
      .skip_i   (face_q == 3'(g)),
      .ok_i     (ok_chain[g]),
      .ok_o     (ok_chain[g+1])
    );
  end

  assign div_start = (state_q == S_CHK) && ok_chain[NumFaces] && !sat;

  rbi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dm_i    (dm_q),
    .cm_i    (cm_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      face_q  <= '0;
      bit_q   <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
      dist_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= '0;
        hi_q[k] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          IdxMinX: lo_q[0] <= cfg_data_i[CoordWidth-1:0];
          IdxMinY: lo_q[1] <= cfg_data_i[CoordWidth-1:0];
          IdxMinZ: lo_q[2] <= cfg_data_i[CoordWidth-1:0];
          IdxMaxX: hi_q[0] <= cfg_data_i[CoordWidth-1:0];
          IdxMaxY: hi_q[1] <= cfg_data_i[CoordWidth-1:0];
          IdxMaxZ: hi_q[2] <= cfg_data_i[CoordWidth-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            org_q[0] <= origin_x_i[CoordWidth-1:0];
            org_q[1] <= origin_y_i[CoordWidth-1:0];
            org_q[2] <= origin_z_i[CoordWidth-1:0];
            dir_q[0] <= direction_x_i[CoordWidth-1:0];
            dir_q[1] <= direction_y_i[CoordWidth-1:0];
            dir_q[2] <= direction_z_i[CoordWidth-1:0];
            face_q   <= '0;
            state_q  <= S_FACE;
          end
        end
        S_FACE: begin
          dm_q  <= dm;
          cm_q  <= cm;
          bit_q <= MulBitW'(PlaneWidth - 1);
          if (dm < NearLsb) begin
            done_q  <= 1'b1;
            hit_q   <= 1'b1;
            dist_q  <= '0;
            state_q <= S_IDLE;
          end else if (cm < NearLsb || dist_s[PlaneWidth-1] == cos_s[PlaneWidth-1]) begin
            if (face_q == LastFace) begin
              done_q  <= 1'b1;
              hit_q   <= 1'b0;
              dist_q  <= '0;
              state_q <= S_IDLE;
            end else begin
              face_q <= face_q + 1'b1;
            end
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (ok_chain[NumFaces]) begin
            if (sat) begin
              done_q  <= 1'b1;
              hit_q   <= 1'b1;
              dist_q  <= DistMax;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_DIV;
            end
          end else if (face_q == LastFace) begin
            done_q  <= 1'b1;
            hit_q   <= 1'b0;
            dist_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            face_q  <= face_q + 1'b1;
            state_q <= S_FACE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            done_q  <= 1'b1;
            hit_q   <= 1'b1;
            dist_q  <= div_quo;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;

endmodule

// ===== sim/rbi_checker.sv =====
// Checker for the ray/box intersection unit: follows box writes, predicts each ray's
// result and compares it with the unit's strobed output. Depends on rbi_pkg only.
`timescale 1ns / 1ps
module rbi_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic signed [31:0]            origin_x_i,
  input  logic signed [31:0]            origin_y_i,
  input  logic signed [31:0]            origin_z_i,
  input  logic signed [31:0]            direction_x_i,
  input  logic signed [31:0]            direction_y_i,
  input  logic signed [31:0]            direction_z_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          done_i,
  input  logic                          hit_i,
  input  logic [rbi_pkg::DistWidth-1:0] hit_distance_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            hit_cnt_o,
  output int                            result_cnt_o
);
  import rbi_pkg::*;

  localparam int NumAxes = 3;
  localparam longint NearTol = 10;
  localparam longint Slack   = 98;

  typedef struct packed {
    logic                 hit;
    logic [DistWidth-1:0] distance;
  } hit_result_t;

  hit_result_t expected_hits[$];
  logic signed [31:0] box_lo[NumAxes];
  logic signed [31:0] box_hi[NumAxes];

  function automatic int axis_of(int f);
    return (f < 2) ? 1 : (f < 4) ? 0 : 2;
  endfunction

  function automatic longint plane_value(int f, longint p[NumAxes]);
    int a;
    a = axis_of(f);
    return (f % 2) ? longint'(box_hi[a]) - p[a] : p[a] - longint'(box_lo[a]);
  endfunction

  function automatic longint plane_cosine(int f, longint d[NumAxes]);
    int a;
    a = axis_of(f);
    return (f % 2) ? -d[a] : d[a];
  endfunction

  function automatic hit_result_t intersect_box(longint o[NumAxes], longint d[NumAxes]);
    hit_result_t r;
    longint dist_v, cosv, dm, cm, t;
    logic signed [127:0] acc;
    bit ok;
    r.hit      = 1'b0;
    r.distance = '0;
    for (int f = 0; f < NumFaces; f++) begin
      dist_v = plane_value(f, o);
      cosv   = plane_cosine(f, d);
      dm     = dist_v < 0 ? -dist_v : dist_v;
      cm     = cosv < 0 ? -cosv : cosv;
      if (dm < NearTol) begin
        r.hit = 1'b1;
        return r;
      end
      if (cm < NearTol) continue;
      if ((dist_v < 0) == (cosv < 0)) continue;
      ok = 1'b1;
      for (int j = 0; j < NumFaces; j++) begin
        if (j == f) continue;
        acc = 128'(plane_value(j, o) + Slack) * 128'(cm)
            + 128'(plane_cosine(j, d)) * 128'(dm);
        if (acc < 0) ok = 1'b0;
      end
      if (!ok) continue;
      r.hit = 1'b1;
      if (dm >= (cm << (DistWidth - FracBits))) begin
        r.distance = DistMax;
      end else begin
        t = (dm << FracBits) / cm;
        r.distance = (t > longint'(DistMax)) ? DistMax : DistWidth'(t);
      end
      return r;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint o[NumAxes], d[NumAxes];
    hit_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NumAxes; k++) begin
        box_lo[k] = '0;
        box_hi[k] = '0;
      end
      expected_hits.delete();
      fail_cnt_o   <= 0;
      hit_cnt_o    <= 0;
      result_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < NumAxes) box_lo[cfg_idx_i[1:0]] = cfg_data_i;
        else if (cfg_idx_i < 2 * NumAxes) box_hi[2'(cfg_idx_i - 3'(NumAxes))] = cfg_data_i;
      end
      if (done_i) begin
        result_cnt_o <= result_cnt_o + 1;
        if (hit_i) hit_cnt_o <= hit_cnt_o + 1;
        if (expected_hits.size() == 0) begin
          $error("result with no ray waiting: hit %0d distance %0d", hit_i, hit_distance_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = expected_hits.pop_front();
          if (hit_i !== want.hit || hit_distance_i !== want.distance) begin
            if (hit_i !== want.hit)
              $error("hit: expected %0d, actual %0d", want.hit, hit_i);
            if (hit_distance_i !== want.distance)
              $error("hit_distance: expected %0d, actual %0d", want.distance,
                     hit_distance_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        o[0] = origin_x_i;    o[1] = origin_y_i;    o[2] = origin_z_i;
        d[0] = direction_x_i; d[1] = direction_y_i; d[2] = direction_z_i;
        expected_hits.push_back(intersect_box(o, d));
      end
    end
  end

  assign pending_o = expected_hits.size();

endmodule

// ===== sim/tb.sv =====
// Testbench top for ray_box_intersect_unit: drives rays and box writes with random
// gaps and gives the verdict. Depends on rbi_pkg, rbi_checker and the unit itself.
`timescale 1ns / 1ps
module tb;
  import rbi_pkg::*;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0, REG_MIN_Y = 3'd1, REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3, REG_MAX_Y = 3'd4, REG_MAX_Z = 3'd5,
    REG_SPARE = 3'd7
  } box_reg_e;

  localparam longint One = 65536;
  localparam int RandomRays = 1700;
  localparam int IdleLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] direction_x_i = '0, direction_y_i = '0, direction_z_i = '0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic done_o, hit_o;
  logic [DistWidth-1:0] hit_distance_o;
  int fail_cnt, pending, hit_cnt, result_cnt, ray_cnt, box_cnt, idle_cycles;
  longint box_min[3], box_max[3];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ray_box_intersect_unit dut (.*);

  rbi_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .origin_x_i, .origin_y_i, .origin_z_i,
    .direction_x_i, .direction_y_i, .direction_z_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_i(done_o), .hit_i(hit_o), .hit_distance_i(hit_distance_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .hit_cnt_o(hit_cnt), .result_cnt_o(result_cnt)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("ray_box_intersect_unit test failed");
      $finish;
    end
  end

  function automatic longint spread(longint range);
    return longint'($urandom_range(0, 2 * range)) - range;
  endfunction

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
  endtask

  task automatic set_box(longint mn[3], longint mx[3]);
    drain();
    for (int k = 0; k < 3; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= box_reg_e'(REG_MIN_X + k);
      cfg_data_i <= 32'(mn[k]);
      @(posedge clk_i);
      cfg_idx_i <= box_reg_e'(REG_MAX_X + k);
      cfg_data_i <= 32'(mx[k]);
      @(posedge clk_i);
      box_min[k] = longint'(signed'(32'(mn[k])));
      box_max[k] = longint'(signed'(32'(mx[k])));
    end
    cfg_idx_i <= REG_SPARE;
    cfg_data_i <= 32'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    box_cnt++;
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) < 7) ? 0 : ($urandom_range(0, 9) == 0 ?
        $urandom_range(20, 300) : $urandom_range(1, 4));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_ray(longint ox, longint oy, longint oz,
                          longint dx, longint dy, longint dz);
    start <= 1'b1;
    origin_x_i <= 32'(ox);    origin_y_i <= 32'(oy);    origin_z_i <= 32'(oz);
    direction_x_i <= 32'(dx); direction_y_i <= 32'(dy); direction_z_i <= 32'(dz);
    do @(posedge clk_i); while (busy);
    ray_cnt++;
    gap();
  endtask

  task automatic random_ray();
    longint o[3], d[3], tgt[3], span;
    int kind, f, a;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      span = box_max[k] - box_min[k];
      if (span < 0) span = -span;
      o[k] = (box_min[k] + box_max[k]) / 2 + spread(span + 8 * One);
      tgt[k] = (box_min[k] + box_max[k]) / 2 + spread(span / 2 + One / 4);
      d[k] = spread(2 * One);
    end
    if (kind < 6) begin
      for (int k = 0; k < 3; k++) d[k] = (tgt[k] - o[k]) >>> $urandom_range(0, 6);
    end else if (kind == 6) begin
      f = $urandom_range(0, 5);
      a = (f < 2) ? 1 : (f < 4) ? 0 : 2;
      o[a] = ((f % 2) ? box_max[a] : box_min[a]) + spread(14);
    end else if (kind == 7) begin
      d[$urandom_range(0, 2)] = spread(15);
    end else begin
      for (int k = 0; k < 3; k++) begin
        o[k] = longint'($urandom);
        d[k] = longint'($urandom);
      end
    end
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endtask

  initial begin
    longint mn[3], mx[3];
    ray_cnt = 0;
    box_cnt = 0;
    for (int k = 0; k < 3; k++) begin
      box_min[k] = 0;
      box_max[k] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_ray(-3 * One, 0, 0, One, 0, 0);
    send_ray(5, 3, -4, One, One, One);
    mn = '{-2 * One, -2 * One, -2 * One};
    mx = '{2 * One, 2 * One, 2 * One};
    set_box(mn, mx);
    send_ray(-8 * One, 0, 0, One, 0, 0);
    send_ray(8 * One, 0, 0, -One, 0, 0);
    send_ray(0, -8 * One, 0, 0, One, 0);
    send_ray(0, 8 * One, 0, 0, -One, 0);
    send_ray(0, 0, -8 * One, 0, 0, One);
    send_ray(0, 0, 8 * One, 0, 0, -One);
    send_ray(0, 0, 0, One, One / 3, -One / 5);
    send_ray(-2 * One + 3, 5 * One, 0, 0, 0, 0);
    send_ray(7 * One, 2 * One - 9, 7 * One, One, One, One);
    send_ray(-8 * One, 0, 0, 5, 0, 0);
    send_ray(-8 * One, 0, 0, -One, 0, 0);
    send_ray(-8 * One, 3 * One, 0, One, 0, 0);
    send_ray(-8 * One, 2 * One + 90, 0, One, 0, 0);
    send_ray(-30000 * One, 0, 0, 20, 0, 0);
    send_ray(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
             -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
    send_ray(-32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 0);
    send_ray(-1, -1, -1, 0, 0, 0);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          mn = '{-One, -3 * One, -One / 2};
          mx = '{One, 3 * One, One / 2};
        end
        1: begin
          mn = '{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000};
          mx = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
        end
        2: begin
          mn = '{2 * One, One, 3 * One};
          mx = '{-2 * One, -One, -3 * One};
        end
        3: begin
          mn = '{100 * One, -50 * One, 0};
          mx = '{100 * One + 20, -50 * One + 200, 8 * One};
        end
        default: begin
          for (int k = 0; k < 3; k++) begin
            mn[k] = spread(20 * One);
            mx[k] = mn[k] + longint'($urandom_range(0, 10 * One));
          end
        end
      endcase
      set_box(mn, mx);
      for (int n = 0; n < RandomRays / 5; n++) begin
        if (n == RandomRays / 10) drain();
        random_ray();
      end
    end

    drain();
    start <= 1'b0;
    repeat (300) @(posedge clk_i);
    $display("Sent %0d rays against %0d box settings, reset box through extreme corners.",
             ray_cnt, box_cnt);
    $display("Checked %0d results, %0d of them hits.", result_cnt, hit_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ray_box_intersect_unit test passed");
    end else begin
      $display("ray_box_intersect_unit test failed");
    end
    $finish;
  end

endmodule
